// ===== rtl/bgpn_pkg.sv =====
// bgpn_pkg: shared constants, payload structs and state type for the
// block gain peak normalizer
// no dependencies
package bgpn_pkg;

   // block geometry
   localparam int BLOCK_LEN = 64;
   localparam int IDX_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int NUM_BANKS = 2;
   localparam int BANK_W    = 1;
   localparam int RAM_DEPTH = NUM_BANKS * (2 ** IDX_W);
   localparam int BLK_CNT_W = $clog2(NUM_BANKS + 1);

   // descriptor queue between front and back, power of two deep
   localparam int DESC_DEPTH = 2;
   localparam int DPTR_W     = 1;

   // datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int SPROD_W    = GAIN_W + SAMPLE_W + 1;   // signed gain*sample
   localparam int PEAK_W     = 32;
   localparam int PROD_W     = GAIN_W + SAMPLE_W;       // unsigned gain*|sample|
   localparam int Q_FRAC     = 8;                       // Q8.8 gain
   localparam int QMAG_W     = PROD_W - Q_FRAC;
   localparam int NORM_SHIFT = 15;                      // 32767 = 2^15 - 1
   localparam int NUM_W      = PROD_W + NORM_SHIFT;
   localparam int QUO_W      = 17;                      // quotient bits below overflow
   localparam int STEP_W     = $clog2(QUO_W + 1);

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

   // clip thresholds in Q8.8
   localparam logic signed [SPROD_W-1:0] CLIP_HI = SPROD_W'(32767 * 256);
   localparam logic signed [SPROD_W-1:0] CLIP_LO = -SPROD_W'(32768 * 256);

   // saturation magnitudes
   localparam logic [QMAG_W-1:0] SAT_POS_MAG = QMAG_W'(32767);
   localparam logic [QMAG_W-1:0] SAT_NEG_MAG = QMAG_W'(32768);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
      logic                       run_end;
   } rsp_type;

   // one closed block, handed from front to back
   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [IDX_W-1:0]  last_idx;
      logic              clip;
      logic [PEAK_W-1:0] peak;
      logic [GAIN_W-1:0] gain;
   } desc_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_MUL,
      B_CALC,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

// ===== rtl/bgpn_ram.sv =====
// bgpn_ram: generic simple dual port RAM, one write and one registered read
// no dependencies
module bgpn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bgpn_front.sv =====
// bgpn_front: takes samples, writes them to the sample store, tracks clipping
// and the peak, and closes blocks into descriptors; uses bgpn_pkg
module bgpn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  bgpn_pkg::req_type             item,
   input  logic [bgpn_pkg::GAIN_W-1:0]   gain,
   output logic                          ram_wr_en,
   output logic [bgpn_pkg::BANK_W+bgpn_pkg::IDX_W-1:0] ram_wr_addr,
   output logic [bgpn_pkg::SAMPLE_W-1:0] ram_wr_data,
   output logic                          desc_push,
   output bgpn_pkg::desc_type            desc_data
);

   localparam logic [bgpn_pkg::IDX_W-1:0] IDX_LAST = bgpn_pkg::IDX_W'(bgpn_pkg::BLOCK_LEN - 1);

   logic [bgpn_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [bgpn_pkg::BANK_W-1:0] bank_ff, bank_in;
   logic [bgpn_pkg::PEAK_W-1:0] peak_ff, peak_in;
   logic                        clip_ff, clip_in;

   logic signed [bgpn_pkg::SPROD_W-1:0] prod;
   logic signed [bgpn_pkg::SPROD_W-1:0] prod_abs;
   logic [bgpn_pkg::PEAK_W-1:0]         mag;
   logic                                hit;
   logic [bgpn_pkg::PEAK_W-1:0]         peak_new;
   logic                                clip_new;
   logic                                close;

   // scale and classify the incoming sample
   always_comb begin
      prod     = $signed({1'b0, gain}) * item.sample_in;
      hit      = (prod > bgpn_pkg::CLIP_HI) || (prod < bgpn_pkg::CLIP_LO);
      prod_abs = prod[bgpn_pkg::SPROD_W-1] ? -prod : prod;
      mag      = prod_abs[bgpn_pkg::PEAK_W-1:0];
      peak_new = (hit && (mag > peak_ff)) ? mag : peak_ff;
      clip_new = clip_ff | hit;
      close    = item_valid && (item.block_end || (idx_ff == IDX_LAST));
   end

   // store write and descriptor
   always_comb begin
      ram_wr_en          = item_valid;
      ram_wr_addr        = {bank_ff, idx_ff};
      ram_wr_data        = item.sample_in;
      desc_push          = close;
      desc_data.bank     = bank_ff;
      desc_data.last_idx = idx_ff;
      desc_data.clip     = clip_new;
      desc_data.peak     = peak_new;
      desc_data.gain     = gain;
   end

   // block accumulation state
   always_comb begin
      idx_in  = idx_ff;
      bank_in = bank_ff;
      peak_in = peak_ff;
      clip_in = clip_ff;
      if (item_valid) begin
         if (close) begin
            idx_in  = '0;
            bank_in = bank_ff + bgpn_pkg::BANK_W'(1);
            peak_in = '0;
            clip_in = 1'b0;
         end else begin
            idx_in  = idx_ff + bgpn_pkg::IDX_W'(1);
            peak_in = peak_new;
            clip_in = clip_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         bank_ff <= '0;
         peak_ff <= '0;
         clip_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         bank_ff <= bank_in;
         peak_ff <= peak_in;
         clip_ff <= clip_in;
      end
   end

endmodule

// ===== rtl/bgpn_desc_fifo.sv =====
// bgpn_desc_fifo: short queue of closed block descriptors between front and back
// uses bgpn_pkg
module bgpn_desc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgpn_pkg::desc_type push_data,
   input  logic               pop,
   output bgpn_pkg::desc_type pop_data,
   output logic               fifo_empty,
   output logic               fifo_full
);

   bgpn_pkg::desc_type              slot_ff [bgpn_pkg::DESC_DEPTH];
   logic [bgpn_pkg::DPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bgpn_pkg::DPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bgpn_pkg::DPTR_W:0]       cnt_ff, cnt_in;
   logic                            do_push;
   logic                            do_pop;

   // flags and pointer updates
   always_comb begin
      fifo_empty = (cnt_ff == '0);
      fifo_full  = (cnt_ff == (bgpn_pkg::DPTR_W+1)'(bgpn_pkg::DESC_DEPTH));
      do_push    = push && !fifo_full;
      do_pop     = pop && !fifo_empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + bgpn_pkg::DPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + bgpn_pkg::DPTR_W'(1) : rd_ptr_ff;
      cnt_in     = cnt_ff + (bgpn_pkg::DPTR_W+1)'(do_push) - (bgpn_pkg::DPTR_W+1)'(do_pop);
      pop_data   = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/bgpn_back.sv =====
// bgpn_back: reads a closed block back from the sample store, rescales each
// sample (shift, clamp or 17-step divide by peak) and holds the output item
// uses bgpn_pkg
module bgpn_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          desc_empty,
   input  bgpn_pkg::desc_type            desc_data,
   output logic                          desc_pop,
   output logic                          ram_rd_en,
   output logic [bgpn_pkg::BANK_W+bgpn_pkg::IDX_W-1:0] ram_rd_addr,
   input  logic [bgpn_pkg::SAMPLE_W-1:0] ram_rd_data,
   output logic                          bank_release,
   output bgpn_pkg::rsp_type             rsp_data,
   output logic                          empty,
   input  logic                          pop
);

   bgpn_pkg::back_state_type state_ff, state_in;
   bgpn_pkg::desc_type       cur_ff, cur_in;
   logic [bgpn_pkg::IDX_W-1:0]    k_ff, k_in;
   logic                          neg_ff, neg_in;
   logic [bgpn_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [bgpn_pkg::PEAK_W-1:0]   rem_ff, rem_in;
   logic [bgpn_pkg::QUO_W-1:0]    nsh_ff, nsh_in;
   logic [bgpn_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [bgpn_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [bgpn_pkg::SAMPLE_W-1:0] res_ff, res_in;
   logic                          out_valid_ff, out_valid_in;
   bgpn_pkg::rsp_type             out_ff, out_in;

   logic [bgpn_pkg::SAMPLE_W-1:0] smag;
   logic [bgpn_pkg::NUM_W-1:0]    num;
   logic [bgpn_pkg::PEAK_W-1:0]   num_hi;
   logic                          ovf;
   logic [bgpn_pkg::PEAK_W:0]     rem2;
   logic [bgpn_pkg::PEAK_W:0]     diff;
   logic                          ge;
   logic [bgpn_pkg::QUO_W-1:0]    quo_next;
   logic                          is_last;

   // signed saturation of a magnitude, forced to the limit on overflow
   function automatic logic [bgpn_pkg::SAMPLE_W-1:0] sat_sample(
      input logic                        neg,
      input logic                        force_lim,
      input logic [bgpn_pkg::QMAG_W-1:0] q
   );
      logic [bgpn_pkg::QMAG_W-1:0] lim;
      logic [bgpn_pkg::QMAG_W-1:0] m;
      lim = neg ? bgpn_pkg::SAT_NEG_MAG : bgpn_pkg::SAT_POS_MAG;
      m   = (force_lim || (q > lim)) ? lim : q;
      return neg ? -m[bgpn_pkg::SAMPLE_W-1:0] : m[bgpn_pkg::SAMPLE_W-1:0];
   endfunction

   // datapath terms shared by the states
   always_comb begin
      smag     = ram_rd_data[bgpn_pkg::SAMPLE_W-1] ? -ram_rd_data : ram_rd_data;
      num      = {prod_ff, bgpn_pkg::NORM_SHIFT'(0)} - bgpn_pkg::NUM_W'(prod_ff);
      num_hi   = bgpn_pkg::PEAK_W'(num[bgpn_pkg::NUM_W-1:bgpn_pkg::QUO_W]);
      ovf      = (num_hi >= cur_ff.peak);
      rem2     = {rem_ff, nsh_ff[bgpn_pkg::QUO_W-1]};
      diff     = rem2 - {1'b0, cur_ff.peak};
      ge       = (rem2 >= {1'b0, cur_ff.peak});
      quo_next = {quo_ff[bgpn_pkg::QUO_W-2:0], ge};
      is_last  = (k_ff == cur_ff.last_idx);
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      nsh_in       = nsh_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      desc_pop     = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {cur_ff.bank, k_ff};
      bank_release = 1'b0;

      unique case (state_ff)
         bgpn_pkg::B_IDLE: begin
            if (!desc_empty) begin
               desc_pop = 1'b1;
               cur_in   = desc_data;
               k_in     = '0;
               state_in = bgpn_pkg::B_READ;
            end
         end
         bgpn_pkg::B_READ: begin
            // bank is free once its last entry has been read
            ram_rd_en    = 1'b1;
            bank_release = is_last;
            state_in     = bgpn_pkg::B_MUL;
         end
         bgpn_pkg::B_MUL: begin
            neg_in   = ram_rd_data[bgpn_pkg::SAMPLE_W-1];
            prod_in  = cur_ff.gain * smag;
            state_in = bgpn_pkg::B_CALC;
         end
         bgpn_pkg::B_CALC: begin
            if (!cur_ff.clip) begin
               res_in   = sat_sample(neg_ff, 1'b0, prod_ff[bgpn_pkg::PROD_W-1:bgpn_pkg::Q_FRAC]);
               state_in = bgpn_pkg::B_OUT;
            end else if (ovf) begin
               res_in   = sat_sample(neg_ff, 1'b1, '0);
               state_in = bgpn_pkg::B_OUT;
            end else begin
               rem_in   = num_hi;
               nsh_in   = num[bgpn_pkg::QUO_W-1:0];
               quo_in   = '0;
               step_in  = '0;
               state_in = bgpn_pkg::B_DIV;
            end
         end
         bgpn_pkg::B_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = ge ? diff[bgpn_pkg::PEAK_W-1:0] : rem2[bgpn_pkg::PEAK_W-1:0];
            nsh_in  = {nsh_ff[bgpn_pkg::QUO_W-2:0], 1'b0};
            quo_in  = quo_next;
            step_in = step_ff + bgpn_pkg::STEP_W'(1);
            if (step_ff == bgpn_pkg::STEP_W'(bgpn_pkg::QUO_W - 1)) begin
               res_in   = sat_sample(neg_ff, 1'b0, bgpn_pkg::QMAG_W'(quo_next));
               state_in = bgpn_pkg::B_OUT;
            end
         end
         bgpn_pkg::B_OUT: begin
            if (!out_valid_ff || pop) begin
               out_valid_in      = 1'b1;
               out_in.sample_out = res_ff;
               out_in.clipped    = cur_ff.clip;
               out_in.run_end    = is_last;
               if (is_last) begin
                  state_in = bgpn_pkg::B_IDLE;
               end else begin
                  k_in     = k_ff + bgpn_pkg::IDX_W'(1);
                  state_in = bgpn_pkg::B_READ;
               end
            end
         end
         default: begin
            state_in = bgpn_pkg::B_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgpn_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      nsh_ff  <= nsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_data = out_ff;
   assign empty    = !out_valid_ff;

endmodule

// ===== rtl/block_gain_peak_normalizer_top.sv =====
// block_gain_peak_normalizer_top: top level of the block gain peak normalizer
// depends on bgpn_pkg, bgpn_ram, bgpn_front, bgpn_desc_fifo, bgpn_back
//
//   channel  ports                      direction  payload
//   request  push, full, req_data       in         req_type (sample_in, block_end)
//   response empty, pop, rsp_data       out        rsp_type (sample_out, clipped, run_end)
//   csr      csr_we, csr_wdata          in         gain, Q8.8, resets to 256
//
// loading accepts one sample per cycle while full is low; a block closes on block_end
// or at 64 samples; emission steps each sample through read, multiply, scale and
// output, with the 17-step divider in the back end between scale and output when the
// block clipped (a sample past full scale skips the divide); idle follows each block
// two store banks: the front loads one block while the back emits the other;
// full rises while both banks hold closed blocks, and a stalled pop holds the back
// reset is synchronous, no clearing pass; gain returns to unity
module block_gain_peak_normalizer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  bgpn_pkg::req_type           req_data,
   output logic                        empty,
   input  logic                        pop,
   output bgpn_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [bgpn_pkg::GAIN_W-1:0] csr_wdata
);

   localparam int ADDR_W = bgpn_pkg::BANK_W + bgpn_pkg::IDX_W;

   logic [bgpn_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [bgpn_pkg::BLK_CNT_W-1:0] blk_cnt_ff, blk_cnt_in;
   logic                           item_valid;

   logic                           ram_wr_en;
   logic [ADDR_W-1:0]              ram_wr_addr;
   logic [bgpn_pkg::SAMPLE_W-1:0]  ram_wr_data;
   logic                           ram_rd_en;
   logic [ADDR_W-1:0]              ram_rd_addr;
   logic [bgpn_pkg::SAMPLE_W-1:0]  ram_rd_data;

   logic                           desc_push;
   bgpn_pkg::desc_type             desc_in_data;
   logic                           desc_pop;
   bgpn_pkg::desc_type             desc_out_data;
   logic                           desc_empty;
   logic                           desc_full;
   logic                           bank_release;

   // gain register
   always_comb begin
      gain_in = csr_we ? csr_wdata : gain_ff;
   end

   // count of closed blocks still holding a bank
   always_comb begin
      item_valid = push && !full;
      full       = (blk_cnt_ff == bgpn_pkg::BLK_CNT_W'(bgpn_pkg::NUM_BANKS));
      blk_cnt_in = blk_cnt_ff + bgpn_pkg::BLK_CNT_W'(desc_push)
                 - bgpn_pkg::BLK_CNT_W'(bank_release);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= bgpn_pkg::GAIN_RESET;
         blk_cnt_ff <= '0;
      end else begin
         gain_ff    <= gain_in;
         blk_cnt_ff <= blk_cnt_in;
      end
   end

   bgpn_ram #(
      .WIDTH (bgpn_pkg::SAMPLE_W),
      .DEPTH (bgpn_pkg::RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bgpn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (req_data),
      .gain        (gain_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .desc_push   (desc_push),
      .desc_data   (desc_in_data)
   );

   bgpn_desc_fifo u_desc_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_data  (desc_in_data),
      .pop        (desc_pop),
      .pop_data   (desc_out_data),
      .fifo_empty (desc_empty),
      .fifo_full  (desc_full)
   );

   bgpn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .desc_empty   (desc_empty),
      .desc_data    (desc_out_data),
      .desc_pop     (desc_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .bank_release (bank_release),
      .rsp_data     (rsp_data),
      .empty        (empty),
      .pop          (pop)
   );

`ifndef NO_ASSERTIONS
   // never more closed blocks than banks
   a_blk_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      blk_cnt_ff <= bgpn_pkg::BLK_CNT_W'(bgpn_pkg::NUM_BANKS))
      else $error("more closed blocks than store banks");

   // a closed block always finds room in the descriptor queue
   a_desc_room: assert property (@(posedge clock) disable iff (reset)
      desc_push |-> !desc_full)
      else $error("descriptor pushed into a full queue");

   // a bank is released only while a closed block holds one
   a_release_held: assert property (@(posedge clock) disable iff (reset)
      bank_release |-> (blk_cnt_ff != '0))
      else $error("bank released with no block outstanding");

   // the back end takes a descriptor only when one is waiting
   a_desc_pop: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> !desc_empty)
      else $error("descriptor taken from an empty queue");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench: checks block_gain_peak_normalizer_top against a built-in block predictor
// directed table of gain and sample rows, then random blocks under random stalls on both sides
// depends on bgpn_pkg and block_gain_peak_normalizer_top
module testbench;

   localparam int    DIR_ROWS       = 26;
   localparam int    RANDOM_ITEMS   = 300;
   localparam int    SETTLE_CYCLES  = 30;
   localparam int    TAIL_CYCLES    = 200;
   localparam int    WATCHDOG_LIMIT = 3000;
   localparam int    MAX_REPORTS    = 10;
   localparam longint CLIP_HI_Q     = 32767 * 256;
   localparam longint CLIP_LO_Q     = -32768 * 256;
   localparam logic [bgpn_pkg::GAIN_W-1:0] GAIN_UNITY = 16'd256;

   typedef enum logic {ROW_SAMPLE, ROW_GAIN} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic signed [15:0] value;     // sample, or gain for a gain row
      logic               last;
      logic               pinned;    // expected output typed in below
      logic signed [15:0] exp_out;
      logic               exp_clip;
   } stim_row_type;

   // directed rows: reset gain, extremes, clipping, mid-block gain change, saturation
   stim_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{ROW_SAMPLE, 16'sd32767,  1'b0, 1'b1, 16'sd32767,  1'b0},
      '{ROW_SAMPLE, -16'sd32768, 1'b0, 1'b1, -16'sd32768, 1'b0},
      '{ROW_SAMPLE, 16'sd0,      1'b0, 1'b1, 16'sd0,      1'b0},
      '{ROW_SAMPLE, -16'sd1,     1'b1, 1'b1, -16'sd1,     1'b0},
      '{ROW_GAIN,   16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, -16'sd32768, 1'b0, 1'b1, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd32767,  1'b1, 1'b1, 16'sd0,      1'b0},
      '{ROW_GAIN,   16'sd512,    1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd16384,  1'b0, 1'b1, 16'sd32767,  1'b1},
      '{ROW_SAMPLE, -16'sd16384, 1'b0, 1'b1, -16'sd32767, 1'b1},
      '{ROW_SAMPLE, 16'sd100,    1'b0, 1'b1, 16'sd199,    1'b1},
      '{ROW_SAMPLE, -16'sd100,   1'b1, 1'b1, -16'sd199,   1'b1},
      '{ROW_GAIN,   16'hFFFF,    1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, -16'sd32768, 1'b0, 1'b1, -16'sd32767, 1'b1},
      '{ROW_SAMPLE, 16'sd32767,  1'b0, 1'b1, 16'sd32766,  1'b1},
      '{ROW_SAMPLE, 16'sd1,      1'b0, 1'b1, 16'sd0,      1'b1},
      '{ROW_SAMPLE, -16'sd1,     1'b1, 1'b1, 16'sd0,      1'b1},
      '{ROW_GAIN,   16'sd256,    1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd20000,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_GAIN,   16'sd1024,   1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd10000,  1'b1, 1'b0, 16'sd0,      1'b0},
      '{ROW_GAIN,   16'sd300,    1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd30000,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, -16'sd5,     1'b0, 1'b0, 16'sd0,      1'b0},
      '{ROW_SAMPLE, 16'sd7,      1'b1, 1'b0, 16'sd0,      1'b0},
      '{ROW_GAIN,   16'sd256,    1'b0, 1'b0, 16'sd0,      1'b0}
   };

   logic                        clock;
   logic                        reset;
   logic                        push;
   logic                        full;
   bgpn_pkg::req_type           req_data;
   logic                        empty;
   logic                        pop;
   bgpn_pkg::rsp_type           rsp_data;
   logic                        csr_we;
   logic [bgpn_pkg::GAIN_W-1:0] csr_wdata;

   // pinned expectation travelling with the item on the request side
   logic               pin_valid;
   logic signed [15:0] pin_out;
   logic               pin_clip;

   // predictor state
   logic [bgpn_pkg::GAIN_W-1:0] gain_now;
   logic signed [15:0] blk_samples   [bgpn_pkg::BLOCK_LEN];
   logic               blk_pinned    [bgpn_pkg::BLOCK_LEN];
   logic signed [15:0] blk_pin_out   [bgpn_pkg::BLOCK_LEN];
   logic               blk_pin_clip  [bgpn_pkg::BLOCK_LEN];
   int                 blk_fill;
   longint             blk_peak;
   logic               blk_clip;
   bgpn_pkg::rsp_type  expected_outputs [$];

   int  bad_results  = 0;
   int  quiet_cycles = 0;
   bit  feed_steady  = 0;
   bit  drain_steady = 0;
   int  pop_hold     = 0;

   block_gain_peak_normalizer_top uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle lengths: mostly none or short, a few long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'($urandom_range(0, 65535));
      if (r < 60) return 16'(int'($urandom_range(0, 511)) - 256);
      if (r < 85) begin
         if ($urandom_range(0, 1) == 1) return 16'(-int'($urandom_range(0, 20000)));
         return 16'($urandom_range(0, 20000));
      end
      case ($urandom_range(0, 3))
         0:       return 16'sd32767;
         1:       return -16'sd32768;
         2:       return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   function automatic logic [bgpn_pkg::GAIN_W-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return GAIN_UNITY;
      if (r < 25) return '0;
      if (r < 35) return '1;
      if (r < 65) return bgpn_pkg::GAIN_W'($urandom_range(1, 512));
      return bgpn_pkg::GAIN_W'($urandom_range(0, 65535));
   endfunction

   // most blocks short, some medium, a few running into the store limit
   function automatic int pick_block_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 40);
      return $urandom_range(60, 70);
   endfunction

   // block predictor: track clipping per sample, emit the whole block on its close
   function automatic void take_sample(input bgpn_pkg::req_type item, input logic pinned,
                                       input logic signed [15:0] p_out, input logic p_clip);
      longint            scaled;
      longint            outv;
      bgpn_pkg::rsp_type r;
      int                k;
      scaled = longint'(gain_now) * longint'(item.sample_in);
      if (scaled > CLIP_HI_Q || scaled < CLIP_LO_Q) begin
         blk_clip = 1'b1;
         if (scaled < 0) scaled = -scaled;
         if (scaled > blk_peak) blk_peak = scaled;
      end
      blk_samples[blk_fill]  = item.sample_in;
      blk_pinned[blk_fill]   = pinned;
      blk_pin_out[blk_fill]  = p_out;
      blk_pin_clip[blk_fill] = p_clip;
      blk_fill++;
      if (!item.block_end && blk_fill < bgpn_pkg::BLOCK_LEN) return;
      for (k = 0; k < blk_fill; k++) begin
         scaled = longint'(gain_now) * longint'(blk_samples[k]);
         // signed division truncates toward zero
         if (blk_clip) outv = (scaled * 32767) / blk_peak;
         else outv = scaled / 256;
         if (outv > 32767) outv = 32767;
         else if (outv < -32768) outv = -32768;
         r.sample_out = outv[15:0];
         r.clipped    = blk_clip;
         r.run_end    = (k == blk_fill - 1);
         if (blk_pinned[k]) begin
            r.sample_out = blk_pin_out[k];
            r.clipped    = blk_pin_clip[k];
         end
         expected_outputs.push_back(r);
      end
      blk_fill = 0;
      blk_peak = 0;
      blk_clip = 1'b0;
   endfunction

   // offer one item from a falling edge, wait for it to be taken
   task automatic send_sample(input logic signed [15:0] s, input logic last, input bit hold,
                              input logic pinned, input logic signed [15:0] p_out,
                              input logic p_clip);
      req_data.sample_in = s;
      req_data.block_end = last;
      pin_valid = pinned;
      pin_out   = p_out;
      pin_clip  = p_clip;
      push      = 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
      if (!hold) push = 1'b0;
   endtask

   // gain only changes once every result is out and the block has settled
   task automatic set_gain(input logic [bgpn_pkg::GAIN_W-1:0] g);
      push = 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata = g;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we      = 1'b0;
      feed_steady = ($urandom_range(0, 3) == 0);
   endtask

   // result side: random stalls with occasional steady stretches
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) drain_steady = !drain_steady;
         if (pop_hold > 0) begin
            pop = 1'b0;
            pop_hold--;
         end else begin
            pop = 1'b1;
            if (!drain_steady && $urandom_range(0, 4) == 0) pop_hold = pick_idle();
         end
      end
   end

   // monitor: feed the predictor and check results at the rising edge
   always @(posedge clock) begin : monitor
      bgpn_pkg::rsp_type want;
      if (reset) begin
         gain_now = GAIN_UNITY;
         blk_fill = 0;
         blk_peak = 0;
         blk_clip = 1'b0;
         expected_outputs.delete();
      end else begin
         if (csr_we) gain_now = csr_wdata;
         if (push && !full) take_sample(req_data, pin_valid, pin_out, pin_clip);
         if (pop && !empty) begin
            if (expected_outputs.size() == 0) begin
               bad_results++;
               if (bad_results <= MAX_REPORTS)
                  $display("unexpected result: out=%0d clip=%0b end=%0b",
                           rsp_data.sample_out, rsp_data.clipped, rsp_data.run_end);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_data.sample_out !== want.sample_out ||
                   rsp_data.clipped !== want.clipped ||
                   rsp_data.run_end !== want.run_end) begin
                  bad_results++;
                  if (bad_results <= MAX_REPORTS)
                     $display({"mismatch: want out=%0d clip=%0b end=%0b,",
                               " got out=%0d clip=%0b end=%0b"},
                              want.sample_out, want.clipped, want.run_end,
                              rsp_data.sample_out, rsp_data.clipped, rsp_data.run_end);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                 i;
      int                 gap;
      int                 left;
      bit                 hold;
      bit                 reconfig;
      logic               last;
      stim_row_type       row;
      push      = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      pin_valid = 1'b0;
      pin_out   = '0;
      pin_clip  = 1'b0;
      reset     = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (i = 0; i < DIR_ROWS; i++) begin
         row = dir_rows[i];
         if (row.kind == ROW_GAIN) begin
            set_gain(row.value);
         end else begin
            gap  = pick_idle();
            hold = (gap == 0) && (i < DIR_ROWS - 1) && (dir_rows[i + 1].kind == ROW_SAMPLE);
            send_sample(row.value, row.last, hold, row.pinned, row.exp_out, row.exp_clip);
            repeat (gap) @(negedge clock);
         end
      end

      // random blocks, gain changed now and then, sometimes mid-block
      left = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (left == 0) left = pick_block_len();
         last = (left == 1) || (i == RANDOM_ITEMS - 1);
         left--;
         gap      = feed_steady ? 0 : pick_idle();
         reconfig = ($urandom_range(0, 29) == 0);
         hold     = (gap == 0) && !reconfig && (i < RANDOM_ITEMS - 1);
         send_sample(pick_sample(), last, hold, 1'b0, 16'sd0, 1'b0);
         repeat (gap) @(negedge clock);
         if (reconfig) set_gain(pick_gain());
      end

      // drain, then watch for stray results
      push = 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (bad_results == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bgpn_pkg.sv
rtl/bgpn_ram.sv
rtl/bgpn_front.sv
rtl/bgpn_desc_fifo.sv
rtl/bgpn_back.sv
rtl/block_gain_peak_normalizer_top.sv
test/testbench.sv
